/* src/dtu_pkg.sv */
// dtu_pkg: shared constants and character tables for the text to utf-8 converter
// charset codes, register indexes and the ebu latin code point lookup
// no dependencies
package dtu_pkg;

	localparam int TEXT_W = 8;
	localparam int CP_W   = 16;
	localparam int CFG_W  = 4;

	// dab charset codes
	localparam logic [CFG_W-1:0] CS_EBU_LATIN = 4'd0;
	localparam logic [CFG_W-1:0] CS_LATIN1    = 4'd4;
	localparam logic [CFG_W-1:0] CS_UCS2BE    = 4'd6;
	localparam logic [CFG_W-1:0] CS_UTF8      = 4'd15;

	// configuration register indexes
	localparam logic REG_CHARSET = 1'b0;
	localparam logic REG_MOT     = 1'b1;

	// byte ranges of the ebu tables
	localparam logic [TEXT_W-1:0] EBU_LOW_MAX  = 8'h1F;
	localparam logic [TEXT_W-1:0] EBU_HIGH_MIN = 8'h7B;

	// code points for ebu bytes 0x00..0x1f (dropped controls hold 0)
	localparam logic [CP_W-1:0] EBU_LOW_CP [0:31] = '{
		16'h0000, 16'h0118, 16'h012E, 16'h0172, 16'h0102, 16'h0116, 16'h010E, 16'h0218,
		16'h021A, 16'h010A, 16'h0000, 16'h0000, 16'h0120, 16'h0139, 16'h017B, 16'h0143,
		16'h0105, 16'h0119, 16'h012F, 16'h0173, 16'h0103, 16'h0117, 16'h010F, 16'h0219,
		16'h021B, 16'h010B, 16'h0147, 16'h011A, 16'h0121, 16'h013A, 16'h017C, 16'h0000
	};

	// code points for ebu bytes 0x7b..0xff
	localparam logic [CP_W-1:0] EBU_HIGH_CP [0:132] = '{
		16'h00AB, 16'h016F, 16'h00BB, 16'h013D, 16'h0126,
		16'h00E1, 16'h00E0, 16'h00E9, 16'h00E8, 16'h00ED, 16'h00EC, 16'h00F3, 16'h00F2,
		16'h00FA, 16'h00F9, 16'h00D1, 16'h00C7, 16'h015E, 16'h00DF, 16'h00A1, 16'h0178,
		16'h00E2, 16'h00E4, 16'h00EA, 16'h00EB, 16'h00EE, 16'h00EF, 16'h00F4, 16'h00F6,
		16'h00FB, 16'h00FC, 16'h00F1, 16'h00E7, 16'h015F, 16'h011F, 16'h0131, 16'h00FF,
		16'h0136, 16'h0145, 16'h00A9, 16'h0122, 16'h011E, 16'h011B, 16'h0148, 16'h0151,
		16'h0150, 16'h20AC, 16'h00A3, 16'h0024, 16'h0100, 16'h0112, 16'h012A, 16'h016A,
		16'h0137, 16'h0146, 16'h013B, 16'h0123, 16'h013C, 16'h0130, 16'h0144, 16'h0171,
		16'h0170, 16'h00BF, 16'h013E, 16'h00B0, 16'h0101, 16'h0113, 16'h012B, 16'h016B,
		16'h00C1, 16'h00C0, 16'h00C9, 16'h00C8, 16'h00CD, 16'h00CC, 16'h00D3, 16'h00D2,
		16'h00DA, 16'h00D9, 16'h0158, 16'h010C, 16'h0160, 16'h017D, 16'h00D0, 16'h013F,
		16'h00C2, 16'h00C4, 16'h00CA, 16'h00CB, 16'h00CE, 16'h00CF, 16'h00D4, 16'h00D6,
		16'h00DB, 16'h00DC, 16'h0159, 16'h010D, 16'h0161, 16'h017E, 16'h0111, 16'h0140,
		16'h00C3, 16'h00C5, 16'h00C6, 16'h0152, 16'h0177, 16'h00DD, 16'h00D5, 16'h00D8,
		16'h00DE, 16'h014A, 16'h0154, 16'h0106, 16'h015A, 16'h0179, 16'h0164, 16'h00F0,
		16'h00E3, 16'h00E5, 16'h00E6, 16'h0153, 16'h0175, 16'h00FD, 16'h00F5, 16'h00F8,
		16'h00FE, 16'h014B, 16'h0155, 16'h0107, 16'h015B, 16'h017A, 16'h0165, 16'h0127
	};

	// the four dropped control values, compared on a 16 bit value
	function automatic logic is_control(input logic [CP_W-1:0] v);
		return (v == 16'h0000) || (v == 16'h000A) || (v == 16'h000B) || (v == 16'h001F);
	endfunction

	function automatic logic is_surrogate(input logic [CP_W-1:0] v);
		return (v >= 16'hD800) && (v <= 16'hDFFF);
	endfunction

	// ebu latin byte to code point
	function automatic logic [CP_W-1:0] ebu_to_cp(input logic [TEXT_W-1:0] b);
		logic [TEXT_W-1:0] hi_idx;
		logic [CP_W-1:0]   cp;
		hi_idx = b - EBU_HIGH_MIN;
		if (b <= EBU_LOW_MAX) begin
			cp = EBU_LOW_CP[b[4:0]];
		end else if (b >= EBU_HIGH_MIN) begin
			cp = EBU_HIGH_CP[hi_idx];
		end else begin
			case (b)
				8'h24:   cp = 16'h0142;
				8'h5C:   cp = 16'h016E;
				8'h5E:   cp = 16'h0141;
				8'h60:   cp = 16'h0104;
				default: cp = {8'h00, b};
			endcase
		end
		return cp;
	endfunction

endpackage

/* src/dab_text_to_utf8_converter_top.sv */
// dab_text_to_utf8_converter_top: dab label text bytes to utf-8 bytes
// depends on dtu_pkg for charset codes, control checks and ebu tables
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = text_byte, s_tlast = end_of_text
//  m_*     | out | m_tvalid/m_tready  | m_tdata = utf8_byte, m_tlast = run_last
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data (charset_id, mot_mode)
//
// each request is decoded into a code point as it is taken into stage 1,
// stage 2 holds its one to three utf-8 bytes, as set by the utf-8 length,
// and hands out one per cycle while m_tready is high
// a new request is taken every cycle while stage 1 is free or moving on
// requests that yield nothing are dropped at the input
// arst_n clears config, pairing state and all valid flags
module dab_text_to_utf8_converter_top
	import dtu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// input text stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] text_byte
	input  logic              s_tlast,   // end_of_text
	// output utf-8 stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] utf8_byte
	output logic              m_tlast    // run_last
);

	// configuration registers
	logic [CFG_W-1:0] charset_q;
	logic             mot_q;

	// ucs-2 pairing state
	logic [TEXT_W-1:0] pending_q;
	logic              phase_q;

	// stage 1: decoded code point or raw passthrough byte
	logic              valid_s1;
	logic [CP_W-1:0]   cp_s1;
	logic              raw_s1;

	// stage 2: encoded bytes and read pointer
	logic              valid_s2;
	logic [TEXT_W-1:0] byte0_s2, byte1_s2, byte2_s2;
	logic [1:0]        cnt_s2;
	logic [1:0]        idx_q;

	logic              s_fire, m_fire, last_byte, load_s2;
	logic              ucs2_mode;
	logic              dec_emit, dec_raw;
	logic [CP_W-1:0]   dec_cp, pair_val;

	assign ucs2_mode = (charset_q == CS_UCS2BE) && !mot_q;
	assign pair_val  = {pending_q, s_tdata};

	assign m_fire    = m_tvalid && m_tready;
	assign last_byte = (idx_q == (cnt_s2 - 2'd1));
	assign load_s2   = !valid_s2 || (m_fire && last_byte);
	assign s_tready  = !valid_s1 || load_s2;
	assign s_fire    = s_tvalid && s_tready;

	// decode of one input byte into a code point, or nothing
	always_comb begin
		dec_emit = 1'b0;
		dec_raw  = 1'b0;
		dec_cp   = {8'h00, s_tdata};
		if (ucs2_mode) begin
			// only the low byte of a pair yields output
			dec_cp   = pair_val;
			dec_emit = phase_q && !is_control(pair_val) && !is_surrogate(pair_val);
		end else if (!is_control({8'h00, s_tdata})) begin
			case (charset_q)
				CS_EBU_LATIN: begin
					dec_cp   = ebu_to_cp(s_tdata);
					dec_emit = 1'b1;
				end
				CS_LATIN1: begin
					dec_emit = mot_q;
				end
				CS_UTF8: begin
					dec_raw  = 1'b1;
					dec_emit = 1'b1;
				end
				default: begin
					dec_emit = 1'b0;
				end
			endcase
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charset_q <= CS_EBU_LATIN;
			mot_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHARSET: charset_q <= cfg_data;
				REG_MOT:     mot_q     <= cfg_data[0];
				default:     charset_q <= charset_q;
			endcase
		end
	end

	// pairing state follows every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			phase_q   <= 1'b0;
		end else if (s_fire) begin
			if (ucs2_mode) begin
				if (!phase_q) begin
					pending_q <= s_tdata;
					phase_q   <= !s_tlast;
				end else begin
					phase_q   <= 1'b0;
				end
			end else if (s_tlast) begin
				phase_q <= 1'b0;
			end
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= dec_emit;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cp_s1  <= dec_cp;
			raw_s1 <= dec_raw;
		end
	end

	// stage 2: utf-8 encode on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
			idx_q    <= 2'd0;
		end else if (m_fire) begin
			idx_q    <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			if (raw_s1 || (cp_s1 <= 16'h007F)) begin
				// single byte: ascii or utf-8 passthrough
				cnt_s2   <= 2'd1;
				byte0_s2 <= cp_s1[7:0];
				byte1_s2 <= cp_s1[7:0];
				byte2_s2 <= cp_s1[7:0];
			end else if (cp_s1 <= 16'h07FF) begin
				cnt_s2   <= 2'd2;
				byte0_s2 <= {3'b110, cp_s1[10:6]};
				byte1_s2 <= {2'b10, cp_s1[5:0]};
				byte2_s2 <= {2'b10, cp_s1[5:0]};
			end else begin
				cnt_s2   <= 2'd3;
				byte0_s2 <= {4'b1110, cp_s1[15:12]};
				byte1_s2 <= {2'b10, cp_s1[11:6]};
				byte2_s2 <= {2'b10, cp_s1[5:0]};
			end
		end
	end

	// output mux
	always_comb begin
		case (idx_q)
			2'd0:    m_tdata = byte0_s2;
			2'd1:    m_tdata = byte1_s2;
			default: m_tdata = byte2_s2;
		endcase
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_byte;

`ifndef SYNTHESIS
	// read pointer never runs past the encoded length
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q < cnt_s2))
		else $error("read pointer beyond encoded length");

	// a held byte of stage 2 is never a zero-length item
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != 2'd0))
		else $error("empty item in stage 2");

	// a ucs-2 high byte without end of text arms the low byte phase
	a_pair_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && ucs2_mode && !phase_q && !s_tlast && !cfg_we) |=> phase_q)
		else $error("pair phase not armed after high byte");

	// stage 1 empty means the input is open
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input blocked with empty stage 1");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for dab_text_to_utf8_converter_top, with directed and random text
// predicts utf-8 bytes per accepted text request and checks the output stream in order
// depends on dtu_pkg and the converter rtl
module tb;
	import dtu_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 7;
	// drain time after the last expected byte: two stages, plus margin
	localparam int QUIET_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 27;

	// byte values the random text leans on
	localparam logic [7:0] DROP_BYTES    [4] = '{8'h00, 8'h0A, 8'h0B, 8'h1F};
	localparam logic [7:0] SPECIAL_BYTES [8] = '{8'h24, 8'h5C, 8'h5E, 8'h60,
		8'h7B, 8'h7F, 8'h80, 8'hFF};
	// charset codes no mode accepts
	localparam logic [CFG_W-1:0] ODD_CHARSETS [4] = '{4'd1, 4'd3, 4'd7, 4'd14};

	typedef enum {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_mode_t;

	// one text request waiting for the driver
	typedef struct {
		logic [7:0] chr;
		logic       eot;
		bit         wait_drain;
	} text_req_t;

	// one expected utf-8 output byte
	typedef struct {
		logic [7:0] code_unit;
		logic       last;
	} utf8_out_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_CHARSET;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;

	text_req_t text_q[$];
	utf8_out_t utf8_q[$];

	// predictor copy of config and ucs-2 pairing state, matching reset
	logic [CFG_W-1:0] cur_charset = CS_EBU_LATIN;
	logic             cur_mot = 1'b0;
	logic [7:0]       hold_byte = 8'h00;
	logic             low_expected = 1'b0;

	bit req_pending = 1'b0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	dab_text_to_utf8_converter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------
	// utf-8 predictor
	// ---------------------------------------------------------------

	// append one expected byte at the tail of the expectation queue
	task automatic queue_utf8(input utf8_out_t u);
		utf8_q.insert(utf8_q.size(), u);
	endtask

	// the four control values dropped in every charset
	function automatic bit is_dropped(input logic [15:0] v);
		return v == 16'h0000 || v == 16'h000A || v == 16'h000B || v == 16'h001F;
	endfunction

	function automatic logic [15:0] ebu_code_point(input logic [7:0] b);
		logic [7:0]  hi_idx;
		logic [15:0] cp;
		hi_idx = b - EBU_HIGH_MIN;
		if (b <= EBU_LOW_MAX) begin
			cp = EBU_LOW_CP[b[4:0]];
		end else if (b >= EBU_HIGH_MIN) begin
			cp = EBU_HIGH_CP[hi_idx];
		end else begin
			// four ascii positions that ebu latin redefines
			case (b)
				8'h24:   cp = 16'h0142;
				8'h5C:   cp = 16'h016E;
				8'h5E:   cp = 16'h0141;
				8'h60:   cp = 16'h0104;
				default: cp = {8'h00, b};
			endcase
		end
		return cp;
	endfunction

	// queue the utf-8 bytes of a 16 bit code point, surrogates give none
	task automatic expect_code_point(input logic [15:0] cp);
		if (cp < 16'h0080) begin
			queue_utf8(utf8_out_t'{cp[7:0], 1'b1});
		end else if (cp < 16'h0800) begin
			queue_utf8(utf8_out_t'{{3'b110, cp[10:6]}, 1'b0});
			queue_utf8(utf8_out_t'{{2'b10, cp[5:0]}, 1'b1});
		end else if (cp < 16'hD800 || cp > 16'hDFFF) begin
			queue_utf8(utf8_out_t'{{4'b1110, cp[15:12]}, 1'b0});
			queue_utf8(utf8_out_t'{{2'b10, cp[11:6]}, 1'b0});
			queue_utf8(utf8_out_t'{{2'b10, cp[5:0]}, 1'b1});
		end
	endtask

	// one accepted text request: update pairing state, queue its bytes
	task automatic convert_text(input logic [7:0] b, input logic eot);
		logic [15:0] pair;
		if (cur_charset == CS_UCS2BE && !cur_mot) begin
			if (!low_expected) begin
				// high byte; flagged end of text means an odd trailing byte
				hold_byte = b;
				low_expected = !eot;
			end else begin
				low_expected = 1'b0;
				pair = {hold_byte, b};
				if (!is_dropped(pair))
					expect_code_point(pair);
			end
		end else begin
			if (eot)
				low_expected = 1'b0;
			if (!is_dropped({8'h00, b})) begin
				if (cur_charset == CS_EBU_LATIN)
					expect_code_point(ebu_code_point(b));
				else if (cur_charset == CS_LATIN1 && cur_mot)
					expect_code_point({8'h00, b});
				else if (cur_charset == CS_UTF8)
					queue_utf8(utf8_out_t'{b, 1'b1});
			end
		end
	endtask

	// ---------------------------------------------------------------
	// driver: feeds text_q into the slave side
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			req_pending = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				convert_text(s_tdata, s_tlast);
				req_pending = 1'b0;
			end
			if (!s_tvalid || s_tready) begin
				// a drain-marked request waits until every expected byte is out
				if (text_q.size() != 0 && !(text_q[0].wait_drain && utf8_q.size() != 0)
						&& $urandom_range(99) >= src_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= text_q[0].chr;
					s_tlast <= text_q[0].eot;
					void'(text_q.pop_front());
					req_pending = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks the master side against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_check
		utf8_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (utf8_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
				end else begin
					want = utf8_q.pop_front();
					if (m_tdata !== want.code_unit)
						report_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.code_unit));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %0b on byte %02h, want %0b",
							m_tlast, m_tdata, want.last));
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_text(input logic [7:0] b, input logic eot, input bit drain = 1'b0);
		text_q.insert(text_q.size(), text_req_t'{b, eot, drain});
	endtask

	// one register write, then the enable drops
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// both registers; only bit 0 of the mot write counts, upper bits random
	task automatic apply_charset(input logic [CFG_W-1:0] cs, input logic mot);
		logic [CFG_W-2:0] junk;
		junk = 3'($urandom_range(7));
		write_reg(REG_CHARSET, cs);
		write_reg(REG_MOT, {junk, mot});
		cur_charset = cs;
		cur_mot = mot;
	endtask

	task automatic set_flow(input flow_mode_t mode);
		case (mode)
			FLOW_FREE:        begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			FLOW_SRC_GAPS:    begin src_idle_pct = 66; sink_stall_pct = 0;  end
			FLOW_SINK_STALLS: begin src_idle_pct = 0;  sink_stall_pct = 66; end
			default:          begin src_idle_pct = 20; sink_stall_pct = 20; end
		endcase
	endtask

	// wait until nothing is queued, in flight or expected, then let the pipe settle
	task automatic wait_quiet();
		while (req_pending || text_q.size() != 0 || utf8_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_text_byte();
		logic [7:0] b;
		case ($urandom_range(9))
			0:       b = DROP_BYTES[2'($urandom_range(3))];
			1, 2:    b = SPECIAL_BYTES[3'($urandom_range(7))];
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	// byte-wise charsets: random text, ends of text now and then
	task automatic fill_bytes(input int n);
		for (int i = 0; i < n; i++)
			push_text(pick_text_byte(), $urandom_range(7) == 0, i == n / 2);
	endtask

	// ucs-2: mostly well-formed pairs, some odd trailing bytes and stray bytes
	task automatic fill_pairs(input int n);
		int         i;
		bit         drained;
		logic [7:0] hi;
		logic [7:0] lo;
		i = 0;
		drained = 1'b0;
		while (i < n) begin
			case ($urandom_range(15))
				0: begin
					// odd trailing byte at end of text
					push_text(8'($urandom_range(255)), 1'b1);
					i++;
				end
				1: begin
					// stray byte that shifts the pairing
					push_text(8'($urandom_range(255)), 1'b0);
					i++;
				end
				default: begin
					case ($urandom_range(5))
						0:       hi = 8'h00;
						1:       hi = 8'hD8 + 8'($urandom_range(7));
						2:       hi = 8'($urandom_range(7));
						default: hi = 8'($urandom_range(255));
					endcase
					if (hi == 8'h00 && $urandom_range(1) == 0)
						lo = DROP_BYTES[2'($urandom_range(3))];
					else
						lo = 8'($urandom_range(255));
					push_text(hi, 1'b0, !drained && i >= n / 2);
					if (i >= n / 2)
						drained = 1'b1;
					push_text(lo, $urandom_range(5) == 0);
					i += 2;
				end
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		set_flow(FLOW_FREE);

		// reset config is ebu latin: dropped controls, hand-mapped bytes, table ends
		push_text(8'h00, 1'b0);
		push_text(8'h0B, 1'b0);
		push_text(8'h24, 1'b0);
		push_text(8'h5C, 1'b0);
		push_text(8'h5E, 1'b0);
		push_text(8'h60, 1'b0);
		push_text(8'hA9, 1'b0);   // euro sign, three bytes
		push_text(8'hFF, 1'b1);
		wait_quiet();

		// latin-1 under mot
		apply_charset(CS_LATIN1, 1'b1);
		push_text(8'h80, 1'b0);
		push_text(8'hFF, 1'b1);
		wait_quiet();

		// utf-8 pass-through, control still dropped
		apply_charset(CS_UTF8, 1'b0);
		push_text(8'h1F, 1'b0);
		push_text(8'hFF, 1'b1);
		wait_quiet();

		// unsupported combinations give nothing
		apply_charset(CS_LATIN1, 1'b0);
		push_text(8'h41, 1'b0);
		wait_quiet();
		apply_charset(CS_UCS2BE, 1'b1);
		push_text(8'h41, 1'b0);
		wait_quiet();

		// ucs-2: control pair, surrogate, top code point, odd trailing byte
		apply_charset(CS_UCS2BE, 1'b0);
		push_text(8'h00, 1'b0);
		push_text(8'h0A, 1'b0);
		push_text(8'hD8, 1'b0, 1'b1);
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b0);
		push_text(8'hFF, 1'b0);
		push_text(8'h41, 1'b1);
		wait_quiet();

		// pairing survives a charset change without end of text
		push_text(8'h12, 1'b0);
		wait_quiet();
		apply_charset(CS_UTF8, 1'b0);
		push_text(8'h41, 1'b0);
		wait_quiet();
		apply_charset(CS_UCS2BE, 1'b0);
		push_text(8'h34, 1'b0);
		wait_quiet();

		// end of text in another charset clears the pending high byte
		push_text(8'h56, 1'b0);
		wait_quiet();
		apply_charset(CS_EBU_LATIN, 1'b0);
		push_text(8'h42, 1'b1);
		wait_quiet();
		apply_charset(CS_UCS2BE, 1'b0);
		push_text(8'h00, 1'b0);
		push_text(8'h41, 1'b0);
		wait_quiet();

		// random phases, rotating charset and flow so each charset sees two flow modes
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_flow(flow_mode_t'((p + p / 4) % 4));
			case (p % 4)
				0: apply_charset(CS_EBU_LATIN, 1'($urandom_range(1)));
				1: apply_charset(CS_UCS2BE, 1'b0);
				2: apply_charset(CS_LATIN1, 1'b1);
				default: apply_charset(CS_UTF8, 1'($urandom_range(1)));
			endcase
			if (cur_charset == CS_UCS2BE)
				fill_pairs(PHASE_ITEMS);
			else
				fill_bytes(PHASE_ITEMS);
			wait_quiet();
		end

		// a few bytes in a charset code nothing accepts
		set_flow(FLOW_BOTH);
		apply_charset(ODD_CHARSETS[2'($urandom_range(3))], 1'($urandom_range(1)));
		fill_bytes(6);
		wait_quiet();

		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
